[hdl/savitzky_golay_slope_filter_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the slope filter
// Concurrent checks clocked on clk_i; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SAVITZKY_GOLAY_SLOPE_FILTER_TOP_DEFINES_SVH
`define SAVITZKY_GOLAY_SLOPE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check outside reset.
`define SGSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// Check at every edge, reset included.
`define SGSF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define SGSF_ASSERT(lbl, prop)
`define SGSF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[hdl/sgsf_pkg.sv]
// ----------------------------------------------------------------------------
// Slope filter package
// Widths, reciprocal constants and pending-result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sgsf_pkg;

  localparam int unsigned SampleW = 16;
  // 2*(a-d)+(b-c) of 16-bit samples fits 19 signed bits
  localparam int unsigned NumW    = 19;
  localparam int unsigned MagW    = NumW - 1;
  localparam int unsigned QuotW   = 15;
  localparam int unsigned WinDepth = 4;

  // floor(x / 10) == (x * Recip10) >> Recip10Shift for all x < 2**18
  localparam int unsigned Recip10Shift = 21;
  localparam int unsigned Recip10W     = 18;
  localparam logic [Recip10W-1:0] Recip10 = Recip10W'(209716);
  localparam logic [MagW-1:0]     RoundBias = MagW'(5);

  // Pending results of one accepted sample, issued lowest bit first
  localparam int unsigned PendW         = 3;
  localparam int unsigned PendSteady    = 0; // slope two samples back
  localparam int unsigned PendFlushNear = 1; // slope one sample back
  localparam int unsigned PendFlushLast = 2; // slope of the last sample

  typedef logic [PendW-1:0] pend_t;
  typedef logic signed [SampleW-1:0] sample_t;

endpackage

`default_nettype wire

[hdl/savitzky_golay_slope_filter_top.sv]
// ----------------------------------------------------------------------------
// Five-point Savitzky-Golay negative slope filter
// Streams trace samples and emits (2*(x[i-2]-x[i+2]) + (x[i-1]-x[i+1]))/10,
// rounded half away from zero, with ends clamped to the first/last sample.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)   tlast
//  s_axis    in   sample[15:0]         is_final
//  m_axis    out  slope[15:0]          end_of_trace
//
//  Results pass through the issue, numerator and divide-by-10 stages.
//  A last sample owes up to three results, issued one per cycle while the
//  stages are not stalled, so it holds the input until its last result issues;
//  otherwise one sample per cycle while m_axis is not stalled.
//  Reset clears the window and all valid flags; no clearing pass.
//  m_axis_tready low stalls the stages back to s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "savitzky_golay_slope_filter_top_defines.svh"

module savitzky_golay_slope_filter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // [15:0] sample
  input  wire logic        s_axis_tlast_i,  // is_final
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // [15:0] slope
  output logic             m_axis_tlast_o   // end_of_trace
);

  // window state: win_q[0] newest
  sgsf_pkg::sample_t win_q [sgsf_pkg::WinDepth];
  logic [1:0]        seen_q;

  // issue stage: snapshot of the window at the accepted sample
  sgsf_pkg::sample_t it_w_q [sgsf_pkg::WinDepth];
  sgsf_pkg::sample_t it_s_q;
  sgsf_pkg::pend_t   pend_q, pend_d, pend_low;

  // numerator stage
  logic                             num_vld_q;
  logic signed [sgsf_pkg::NumW-1:0] num_q, num_d;
  logic                             num_last_q;

  // output stage
  logic        out_vld_q;
  logic [15:0] out_q, out_d;
  logic        out_last_q;

  logic              s_acc, out_rdy, num_rdy, issue, pend_single;
  sgsf_pkg::sample_t s_in;
  sgsf_pkg::sample_t ws [sgsf_pkg::WinDepth];
  sgsf_pkg::sample_t op_a, op_b, op_c, op_d;

  assign s_in    = sgsf_pkg::sample_t'(s_axis_tdata_i);
  assign out_rdy = !out_vld_q || m_axis_tready_i;
  assign num_rdy = !num_vld_q || out_rdy;
  assign issue   = (pend_q != '0) && num_rdy;

  assign pend_low    = pend_q & (~pend_q + sgsf_pkg::PendW'(1));
  assign pend_single = (pend_q & (pend_q - sgsf_pkg::PendW'(1))) == '0;

  assign s_axis_tready_o = (pend_q == '0) || (issue && pend_single);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // first sample of a trace fills the whole window (clamps the start)
  always_comb begin
    for (int i = 0; i < sgsf_pkg::WinDepth; i++) begin
      ws[i] = (seen_q == 2'd0) ? s_in : win_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sgsf_pkg::WinDepth; i++) begin
        win_q[i] <= '0;
      end
      seen_q <= '0;
    end else if (s_acc) begin
      if (s_axis_tlast_i) begin
        for (int i = 0; i < sgsf_pkg::WinDepth; i++) begin
          win_q[i] <= '0;
        end
        seen_q <= '0;
      end else begin
        win_q[0] <= s_in;
        for (int i = 1; i < sgsf_pkg::WinDepth; i++) begin
          win_q[i] <= ws[i-1];
        end
        if (seen_q != 2'd2) begin
          seen_q <= seen_q + 2'd1;
        end
      end
    end
  end

  // pending results of the accepted sample
  always_comb begin
    pend_d = issue ? (pend_q & ~pend_low) : pend_q;
    if (s_acc) begin
      pend_d[sgsf_pkg::PendSteady]    = (seen_q == 2'd2);
      pend_d[sgsf_pkg::PendFlushNear] = s_axis_tlast_i && (seen_q != 2'd0);
      pend_d[sgsf_pkg::PendFlushLast] = s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int i = 0; i < sgsf_pkg::WinDepth; i++) begin
        it_w_q[i] <= ws[i];
      end
      it_s_q <= s_in;
    end
  end

  // operands x[i-2], x[i-1], x[i+1], x[i+2] of the lowest pending result
  always_comb begin
    op_a = it_w_q[3];
    op_b = it_w_q[2];
    op_c = it_w_q[0];
    op_d = it_s_q;
    if (!pend_q[sgsf_pkg::PendSteady]) begin
      if (pend_q[sgsf_pkg::PendFlushNear]) begin
        op_a = it_w_q[2];
        op_b = it_w_q[1];
      end else begin
        op_a = it_w_q[1];
        op_b = it_w_q[0];
      end
      op_c = it_s_q;
    end
  end

  always_comb begin
    num_d = (sgsf_pkg::NumW'(op_a) - sgsf_pkg::NumW'(op_d)) * sgsf_pkg::NumW'(2)
          + (sgsf_pkg::NumW'(op_b) - sgsf_pkg::NumW'(op_c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vld_q <= 1'b0;
    end else if (num_rdy) begin
      num_vld_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      num_q      <= num_d;
      num_last_q <= pend_low[sgsf_pkg::PendFlushLast];
    end
  end

  // round half away from zero: sign * floor((|num| + 5) / 10)
  logic [sgsf_pkg::NumW-1:0]                     num_abs;
  logic [sgsf_pkg::MagW-1:0]                     biased;
  logic [sgsf_pkg::MagW+sgsf_pkg::Recip10W-1:0]  prod;
  logic [sgsf_pkg::QuotW-1:0]                    quot;

  always_comb begin
    num_abs = num_q[sgsf_pkg::NumW-1] ? (~num_q + sgsf_pkg::NumW'(1)) : num_q;
    biased  = num_abs[sgsf_pkg::MagW-1:0] + sgsf_pkg::RoundBias;
    prod    = (sgsf_pkg::MagW+sgsf_pkg::Recip10W)'(biased)
            * (sgsf_pkg::MagW+sgsf_pkg::Recip10W)'(sgsf_pkg::Recip10);
    quot    = prod[sgsf_pkg::Recip10Shift +: sgsf_pkg::QuotW];
    out_d   = num_q[sgsf_pkg::NumW-1] ? (16'd0 - 16'(quot)) : 16'(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_rdy) begin
      out_vld_q <= num_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && num_vld_q) begin
      out_q      <= out_d;
      out_last_q <= num_last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tlast_o  = out_last_q;

  `SGSF_ASSERT(a_last_clears_window, s_acc && s_axis_tlast_i |=> seen_q == 2'd0)
  `SGSF_ASSERT(a_last_owes_flush, s_acc && s_axis_tlast_i |=> pend_q[sgsf_pkg::PendFlushLast])
  `SGSF_ASSERT(a_near_implies_last, pend_q[sgsf_pkg::PendFlushNear] |-> pend_q[sgsf_pkg::PendFlushLast])
  `SGSF_ASSERT(a_num_holds, num_vld_q && !out_rdy |=> num_vld_q && $stable(num_q))
  `SGSF_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !m_axis_tvalid_o && pend_q == '0)

endmodule

`default_nettype wire

[tb/tb_savitzky_golay_slope_filter_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the five-point slope filter
// Streams traces of signed samples with random gaps and output stalls, predicts
// every slope and end-of-trace flag, and checks each output transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_savitzky_golay_slope_filter_top;

  localparam int unsigned IdleLimit   = 500;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned TotalItems  = 230;

  typedef struct packed {
    sgsf_pkg::sample_t slope;
    logic              eot;
  } slope_res_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [15:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // predictor state: last four samples, newest first, and samples seen
  sgsf_pkg::sample_t hist_win [sgsf_pkg::WinDepth];
  int unsigned       hist_seen;

  slope_res_t  slope_q [$];
  int unsigned idle_cycles   = 0;
  int unsigned mismatches    = 0;
  int unsigned samples_in    = 0;
  int unsigned traces_in     = 0;
  int unsigned slopes_seen   = 0;
  int unsigned items_sent    = 0;
  int unsigned burst_left    = 0;
  bit          gaps_on       = 1'b1;

  savitzky_golay_slope_filter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic sgsf_pkg::sample_t neg_slope(sgsf_pkg::sample_t far_lo,
                                                  sgsf_pkg::sample_t near_lo,
                                                  sgsf_pkg::sample_t near_hi,
                                                  sgsf_pkg::sample_t far_hi);
    int num;
    int mag;
    int q;
    num = 2 * (int'(far_lo) - int'(far_hi)) + (int'(near_lo) - int'(near_hi));
    mag = (num < 0) ? -num : num;
    q   = (mag + 5) / 10;
    if (num < 0) q = -q;
    return sgsf_pkg::sample_t'(q);
  endfunction

  function automatic void clear_history();
    for (int i = 0; i < sgsf_pkg::WinDepth; i++) hist_win[i] = '0;
    hist_seen = 0;
  endfunction

  function automatic void predict_slopes(sgsf_pkg::sample_t s, logic fin);
    if (hist_seen == 0) begin
      for (int i = 0; i < sgsf_pkg::WinDepth; i++) hist_win[i] = s;
    end
    if (hist_seen >= 2)
      slope_q.push_back('{neg_slope(hist_win[3], hist_win[2], hist_win[0], s), 1'b0});
    if (fin) begin
      // flush what is still owed, clamping the right edge to the last sample
      if (hist_seen >= 1)
        slope_q.push_back('{neg_slope(hist_win[2], hist_win[1], s, s), 1'b0});
      slope_q.push_back('{neg_slope(hist_win[1], hist_win[0], s, s), 1'b1});
      clear_history();
    end else begin
      for (int i = sgsf_pkg::WinDepth - 1; i > 0; i--) hist_win[i] = hist_win[i-1];
      hist_win[0] = s;
      if (hist_seen < 2) hist_seen++;
    end
  endfunction

  function automatic void report_mismatch(string what, slope_res_t want, slope_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected slope %0d last %0b, got slope %0d last %0b",
               what, want.slope, want.eot, got.slope, got.eot);
  endfunction

  // watch both channels; predict on input transfers, check on output ones
  always @(posedge clk_i) begin
    slope_res_t got;
    slope_res_t want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        predict_slopes(sgsf_pkg::sample_t'(s_tdata), s_tlast);
        samples_in++;
        if (s_tlast) traces_in++;
        moved = 1'b1;
      end
      if (m_axis_tvalid_o && m_tready) begin
        got = '{sgsf_pkg::sample_t'(m_axis_tdata_o), m_axis_tlast_o};
        slopes_seen++;
        moved = 1'b1;
        if (slope_q.size() == 0) begin
          report_mismatch("unexpected", '0, got);
        end else begin
          want = slope_q.pop_front();
          if (got !== want) report_mismatch("value", want, got);
        end
      end
    end
    idle_cycles <= moved ? 0 : idle_cycles + 1;
  end

  // output stalls: periodically switch at random among four ready patterns
  always @(posedge clk_i) begin
    static int unsigned rdy_cyc  = 0;
    static int unsigned rdy_mode = 0;
    if (rdy_cyc % 40 == 0) rdy_mode = $urandom_range(0, 3);
    rdy_cyc++;
    case (rdy_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (rdy_cyc % 4) != 0;
      default: m_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  initial begin
    wait (idle_cycles >= IdleLimit);
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_sample(sgsf_pkg::sample_t s, logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    s_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // let the monitor take the last transfer before looking at the queue
  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (slope_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic sgsf_pkg::sample_t pick_sample();
    case ($urandom_range(0, 3))
      0:       return sgsf_pkg::sample_t'($urandom_range(0, 20)) - sgsf_pkg::sample_t'(10);
      1:       return $urandom_range(0, 1)
                      ? 16'sh7fff - sgsf_pkg::sample_t'($urandom_range(0, 3))
                      : 16'sh8000 + sgsf_pkg::sample_t'($urandom_range(0, 3));
      default: return sgsf_pkg::sample_t'($urandom);
    endcase
  endfunction

  task automatic send_trace(int unsigned len);
    for (int unsigned i = 0; i < len; i++)
      send_sample(pick_sample(), i == len - 1);
  endtask

  // single-sample, two-sample and three-sample traces at the extremes,
  // the largest possible slope, and rounding ties of both signs
  task automatic test_directed_edges();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0005, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0005, 1'b0);
    send_sample(16'sh0000, 1'b1);
  endtask

  // hold off the next trace until every owed slope has come out
  task automatic test_pause_between_traces();
    wait_for_drain();
    send_trace(4);
    wait_for_drain();
    send_trace(1);
    wait_for_drain();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    send_trace(12);
    send_trace(2);
    send_trace(1);
    send_trace(3);
    gaps_on = 1'b1;
  endtask

  task automatic test_random_traces();
    int unsigned len;
    while (items_sent < TotalItems) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
      send_trace(len);
    end
  endtask

  initial begin
    clear_history();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_pause_between_traces();
    test_back_to_back();
    test_random_traces();
    wait_for_drain();

    if (slope_q.size() != 0) begin
      mismatches++;
      $display("%0d expected slopes never arrived", slope_q.size());
    end
    $display("Sent %0d samples in %0d traces; checked %0d slopes under random gaps and stalls",
             samples_in, traces_in, slopes_seen);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
